FILE: hdl/pwsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwsd_pkg
// Shared types, register indexes and timing constants for the PID unit with
// settle detection.
// ----------------------------------------------------------------------------
package pwsd_pkg;

  localparam int MEAS_W  = 24;
  localparam int ERR_W   = 25;
  localparam int DER_W   = 26;
  localparam int INTEG_W = 40;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 24;
  localparam int TIME_W  = 16;
  localparam int TMR_W   = 17;
  localparam int DRIVE_W = 32;
  localparam int IDX_W   = 8;

  localparam int P_W   = ERR_W + GAIN_W;
  localparam int I_W   = INTEG_W + GAIN_W;
  localparam int D_W   = DER_W + GAIN_W;
  localparam int ACC_W = I_W + 2;

  localparam logic [TMR_W-1:0] TICK_MS             = TMR_W'(10);
  localparam logic [TMR_W-1:0] VELOCITY_TIMEOUT_MS = TMR_W'(500);
  localparam logic [TMR_W-1:0] CURRENT_TIMEOUT_MS  = TMR_W'(1000);
  localparam logic [TMR_W-1:0] TIMER_MAX           = {TMR_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_KP          = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_KI          = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_KD          = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_INTEG_BAND  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_SMALL_LIM   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SMALL_HOLD  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_BIG_LIM     = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_BIG_HOLD    = IDX_W'(7);

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_SMALL    = 3'd1,
    ST_BIG      = 3'd2,
    ST_VELOCITY = 3'd3,
    ST_CURRENT  = 3'd4,
    ST_MISSING  = 3'd5
  } status_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]         integral_band;
    logic [LIM_W-1:0]         small_lim;
    logic [TIME_W-1:0]        small_hold;
    logic [LIM_W-1:0]         big_lim;
    logic [TIME_W-1:0]        big_hold;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DER_W-1:0]   der;
    logic signed [INTEG_W-1:0] integ;
    status_t                   status;
  } trk_t;

  function automatic logic [TMR_W-1:0] timer_advance(input logic [TMR_W-1:0] t);
    logic [TMR_W:0] n;
    n = {1'b0, t} + {1'b0, TICK_MS};
    return (n > {1'b0, TIMER_MAX}) ? TIMER_MAX : n[TMR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pid_with_settle_detect_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_with_settle_detect_unit
// PID controller with integral band and settle detection, stream interface.
// ----------------------------------------------------------------------------
// One transaction in is one control tick and gives one transaction out. The
// unit takes a tick every cycle unless the output stalls; the result passes
// the input register, tracking stage, product stage and result register in
// that order. Error, integral and settle timers update in a loop closed in
// the tracking stage; the three gain products have a stage of their own.
// Stalls on the output back up stage by stage, so empty stages still take
// new ticks. Configuration writes are taken every cycle and must be made
// only while no tick is in flight.
module pid_with_settle_detect_unit (
  input  wire         clk,
  input  wire         rst,
  // s_tdata: measured[23:0], setpoint[47:24]
  input  wire  [47:0] s_tdata,
  // s_tuser: over_current[0]
  input  wire         s_tuser,
  input  wire         s_tvalid,
  output logic        s_tready,
  // m_tdata: drive[31:0], status[34:32], zero fill [39:35]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [23:0] cfg_data
);
  import pwsd_pkg::*;

  cfg_t                  cfg;
  trk_t                  trk;
  logic [MEAS_W-1:0]     measured, setpoint;
  logic                  over_current;
  logic                  v0, v1, v2;
  logic                  rdy0, rdy1, rdy2, rdy3;
  logic [DRIVE_W-1:0]    drive;
  status_t               status;

  assign rdy3      = !m_tvalid || m_tready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign s_tready  = rdy0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy0) v0       <= s_tvalid;
      if (rdy1) v1       <= v0;
      if (rdy2) v2       <= v1;
      if (rdy3) m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_tvalid) begin
      measured     <= s_tdata[MEAS_W-1:0];
      setpoint     <= s_tdata[2*MEAS_W-1:MEAS_W];
      over_current <= s_tuser;
    end
  end

  pwsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwsd_track u_track (
    .clk          (clk),
    .rst          (rst),
    .en           (rdy1 && v0),
    .measured     (measured),
    .setpoint     (setpoint),
    .over_current (over_current),
    .cfg          (cfg),
    .trk          (trk)
  );

  pwsd_mac u_mac (
    .clk    (clk),
    .en_mul (rdy2 && v1),
    .en_sum (rdy3 && v2),
    .trk    (trk),
    .cfg    (cfg),
    .drive  (drive),
    .status (status)
  );

  assign m_tdata = {5'b0, status, drive};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready while output register empty");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:32] <= 3'd5)
    else $error("status code out of range");

  a_one_per_tick: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> m_tvalid)
    else $error("result lost between product stage and output");

endmodule
`default_nettype wire

FILE: hdl/pwsd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwsd_cfg_regs
// Configuration register file: gains, integral band and settle limits.
// ----------------------------------------------------------------------------
module pwsd_cfg_regs (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_valid,
  input  wire  [pwsd_pkg::IDX_W-1:0]  cfg_index,
  input  wire  [pwsd_pkg::LIM_W-1:0]  cfg_data,
  output pwsd_pkg::cfg_t              cfg
);
  import pwsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP:          cfg.kp            <= cfg_data[GAIN_W-1:0];
        REG_KI:          cfg.ki            <= cfg_data[GAIN_W-1:0];
        REG_KD:          cfg.kd            <= cfg_data[GAIN_W-1:0];
        REG_INTEG_BAND:  cfg.integral_band <= cfg_data;
        REG_SMALL_LIM:   cfg.small_lim     <= cfg_data;
        REG_SMALL_HOLD:  cfg.small_hold    <= cfg_data[TIME_W-1:0];
        REG_BIG_LIM:     cfg.big_lim       <= cfg_data;
        REG_BIG_HOLD:    cfg.big_hold      <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pwsd_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwsd_track
// Per-tick error, derivative, gated integral and settle timers; holds the
// loop state and registers the values for the gain products.
// ----------------------------------------------------------------------------
module pwsd_track (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire  [pwsd_pkg::MEAS_W-1:0]  measured,
  input  wire  [pwsd_pkg::MEAS_W-1:0]  setpoint,
  input  wire                          over_current,
  input  pwsd_pkg::cfg_t               cfg,
  output pwsd_pkg::trk_t               trk
);
  import pwsd_pkg::*;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  logic signed [INTEG_W-1:0] integral_sum, integral_sum_next;
  logic signed [ERR_W-1:0]   last_error;
  logic [TMR_W-1:0]          small_timer, big_timer, still_timer, current_timer;
  logic [TMR_W-1:0]          small_timer_next, big_timer_next;
  logic [TMR_W-1:0]          still_timer_next, current_timer_next;

  logic signed [ERR_W-1:0]   err;
  logic signed [DER_W-1:0]   der;
  logic [ERR_W-1:0]          mag;
  logic [INTEG_W:0]          integ_add;
  logic                      err_zero, last_zero, sign_change;
  status_t                   status;

  always_comb begin
    err = {setpoint[MEAS_W-1], setpoint} - {measured[MEAS_W-1], measured};
    der = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
    mag = err[ERR_W-1] ? ERR_W'(-err) : err;

    // gated integral with 40-bit saturation and reset on sign change
    integ_add = {integral_sum[INTEG_W-1], integral_sum}
              + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
    err_zero    = (err == '0);
    last_zero   = (last_error == '0);
    sign_change = (err_zero != last_zero) ||
                  (!err_zero && !last_zero && (err[ERR_W-1] != last_error[ERR_W-1]));
    integral_sum_next = integral_sum;
    if (cfg.ki != '0) begin
      if (mag < {1'b0, cfg.integral_band}) begin
        if (integ_add[INTEG_W] != integ_add[INTEG_W-1])
          integral_sum_next = integ_add[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
          integral_sum_next = integ_add[INTEG_W-1:0];
      end
      if (sign_change)
        integral_sum_next = '0;
    end

    // settle checks, first exit wins and clears all timers; a missing limit holds them
    small_timer_next   = small_timer;
    big_timer_next     = big_timer;
    still_timer_next   = still_timer;
    current_timer_next = current_timer;
    status             = ST_RUNNING;
    if (cfg.small_lim == '0 || cfg.small_hold == '0 ||
        cfg.big_lim == '0 || cfg.big_hold == '0) begin
      status = ST_MISSING;
    end else begin
      current_timer_next = over_current ? timer_advance(current_timer) : '0;
      if (over_current && current_timer_next > CURRENT_TIMEOUT_MS) begin
        status = ST_CURRENT;
      end else begin
        if (mag < {1'b0, cfg.small_lim}) begin
          small_timer_next = timer_advance(small_timer);
          big_timer_next   = '0;
        end else begin
          small_timer_next = '0;
        end
        if (mag < {1'b0, cfg.small_lim} &&
            small_timer_next > {1'b0, cfg.small_hold}) begin
          status = ST_SMALL;
        end else begin
          if (mag < {1'b0, cfg.big_lim})
            big_timer_next = timer_advance(big_timer_next);
          else
            big_timer_next = '0;
          if (mag < {1'b0, cfg.big_lim} && big_timer_next > {1'b0, cfg.big_hold}) begin
            status = ST_BIG;
          end else begin
            still_timer_next = (der == '0) ? timer_advance(still_timer) : '0;
            if (der == '0 && still_timer_next > VELOCITY_TIMEOUT_MS)
              status = ST_VELOCITY;
          end
        end
      end
      if (status != ST_RUNNING) begin
        small_timer_next   = '0;
        big_timer_next     = '0;
        still_timer_next   = '0;
        current_timer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum  <= '0;
      last_error    <= '0;
      small_timer   <= '0;
      big_timer     <= '0;
      still_timer   <= '0;
      current_timer <= '0;
    end else if (en) begin
      integral_sum  <= integral_sum_next;
      last_error    <= err;
      small_timer   <= small_timer_next;
      big_timer     <= big_timer_next;
      still_timer   <= still_timer_next;
      current_timer <= current_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trk.err    <= err;
      trk.der    <= der;
      trk.integ  <= integral_sum_next;
      trk.status <= status;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pwsd_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwsd_mac
// Gain products (one register stage), then sum, floor shift by 8 and 32-bit
// saturation into the result register.
// ----------------------------------------------------------------------------
module pwsd_mac (
  input  wire                            clk,
  input  wire                            en_mul,
  input  wire                            en_sum,
  input  pwsd_pkg::trk_t                 trk,
  input  pwsd_pkg::cfg_t                 cfg,
  output logic [pwsd_pkg::DRIVE_W-1:0]   drive,
  output pwsd_pkg::status_t              status
);
  import pwsd_pkg::*;

  logic signed [P_W-1:0]   p_term;
  logic signed [I_W-1:0]   i_term;
  logic signed [D_W-1:0]   d_term;
  status_t                 status_mul;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-9:0] quot;
  logic [DRIVE_W-1:0]      drive_next;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_term     <= P_W'($signed(trk.err) * $signed(cfg.kp));
      i_term     <= I_W'($signed(trk.integ) * $signed(cfg.ki));
      d_term     <= D_W'($signed(trk.der) * $signed(cfg.kd));
      status_mul <= trk.status;
    end
  end

  always_comb begin
    acc  = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);
    quot = acc[ACC_W-1:8];
    if (quot[ACC_W-9:DRIVE_W-1] == '0 || quot[ACC_W-9:DRIVE_W-1] == '1)
      drive_next = quot[DRIVE_W-1:0];
    else
      drive_next = quot[ACC_W-9] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                 : {1'b0, {(DRIVE_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      drive  <= drive_next;
      status <= status_mul;
    end
  end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pid_with_settle_detect_unit. Control ticks go in
// through the input stream and every drive/status transaction coming out is
// compared with a cycle-free predictor of the PID, integral band and settle
// timers. Directed ticks cover field extremes and integral band edges, then
// random episodes (converging, hovering, stuck, overcurrent, noise) run
// under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import pwsd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int END_PAUSE   = 12;
  localparam logic [IDX_W-1:0] REG_UNUSED = REG_BIG_HOLD + IDX_W'(1);
  localparam longint INTEG_HI  = 64'sh0000_007F_FFFF_FFFF;
  localparam longint INTEG_LO  = -INTEG_HI - 1;
  localparam longint DRIVE_HI  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint DRIVE_LO  = -DRIVE_HI - 1;
  localparam longint ERR_CLAMP = 64'sd8388607;
  localparam longint MEAS_SPAN = 64'sd16777215;
  localparam longint MEAS_OFS  = 64'sd8388608;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    status_t                   status;
  } tick_out_t;

  typedef enum {EP_CONVERGE, EP_HOVER, EP_HOLD, EP_OVERLOAD, EP_NOISE} episode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [23:0] cfg_data;

  // predictor state
  cfg_t                      regs = '0;
  logic signed [INTEG_W-1:0] integ_acc = '0;
  logic signed [ERR_W-1:0]   prev_err = '0;
  logic [TMR_W-1:0]          tmr_small = '0;
  logic [TMR_W-1:0]          tmr_big = '0;
  logic [TMR_W-1:0]          tmr_still = '0;
  logic [TMR_W-1:0]          tmr_current = '0;

  tick_out_t pending_ticks[$];
  int ticks_sent = 0;
  int results_seen = 0;
  int bad_results = 0;
  int status_seen[8] = '{default: 0};
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_tgl = 1'b0;
  bit hold_seen = 1'b0;

  pid_with_settle_detect_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int sign_of(longint x);
    if (x > 0) return 1;
    if (x < 0) return -1;
    return 0;
  endfunction

  function automatic logic [TMR_W-1:0] tick_up(logic [TMR_W-1:0] t);
    return (t > TIMER_MAX - TICK_MS) ? TIMER_MAX : t + TICK_MS;
  endfunction

  function automatic void zero_timers();
    tmr_small = '0;
    tmr_big = '0;
    tmr_still = '0;
    tmr_current = '0;
  endfunction

  function automatic status_t settle_check(longint err, longint der, logic oc);
    longint mag;
    mag = (err < 0) ? -err : err;
    if (regs.small_lim == 0 || regs.small_hold == 0 || regs.big_lim == 0 ||
        regs.big_hold == 0)
      return ST_MISSING;
    if (oc) begin
      tmr_current = tick_up(tmr_current);
      if (tmr_current > CURRENT_TIMEOUT_MS) begin
        zero_timers();
        return ST_CURRENT;
      end
    end else begin
      tmr_current = '0;
    end
    if (mag < longint'(regs.small_lim)) begin
      tmr_small = tick_up(tmr_small);
      tmr_big = '0;
      if (tmr_small > {1'b0, regs.small_hold}) begin
        zero_timers();
        return ST_SMALL;
      end
    end else begin
      tmr_small = '0;
    end
    if (mag < longint'(regs.big_lim)) begin
      tmr_big = tick_up(tmr_big);
      if (tmr_big > {1'b0, regs.big_hold}) begin
        zero_timers();
        return ST_BIG;
      end
    end else begin
      tmr_big = '0;
    end
    if (der == 0) begin
      tmr_still = tick_up(tmr_still);
      if (tmr_still > VELOCITY_TIMEOUT_MS) begin
        zero_timers();
        return ST_VELOCITY;
      end
    end else begin
      tmr_still = '0;
    end
    return ST_RUNNING;
  endfunction

  function automatic tick_out_t control_tick(logic signed [MEAS_W-1:0] meas,
                                             logic signed [MEAS_W-1:0] setp, logic oc);
    longint err, der, mag, sum, acc, q;
    tick_out_t r;
    err = longint'(setp) - longint'(meas);
    der = err - longint'(prev_err);
    if (regs.ki != 0) begin
      mag = (err < 0) ? -err : err;
      if (mag < longint'(regs.integral_band)) begin
        sum = longint'(integ_acc) + err;
        if (sum > INTEG_HI) sum = INTEG_HI;
        if (sum < INTEG_LO) sum = INTEG_LO;
        integ_acc = sum[INTEG_W-1:0];
      end
      if (sign_of(err) != sign_of(longint'(prev_err))) integ_acc = '0;
    end
    acc = err * longint'(signed'(regs.kp)) + longint'(integ_acc) * longint'(signed'(regs.ki))
        + der * longint'(signed'(regs.kd));
    q = acc >>> 8;
    if (q > DRIVE_HI) q = DRIVE_HI;
    if (q < DRIVE_LO) q = DRIVE_LO;
    prev_err = err[ERR_W-1:0];
    r.drive = q[DRIVE_W-1:0];
    r.status = settle_check(err, der, oc);
    return r;
  endfunction

  function automatic longint rand_sign(longint x);
    return $urandom_range(1) ? x : -x;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [23:0] val);
    case (idx)
      REG_KP:          regs.kp = val[GAIN_W-1:0];
      REG_KI:          regs.ki = val[GAIN_W-1:0];
      REG_KD:          regs.kd = val[GAIN_W-1:0];
      REG_INTEG_BAND:  regs.integral_band = val;
      REG_SMALL_LIM:   regs.small_lim = val;
      REG_SMALL_HOLD:  regs.small_hold = val[TIME_W-1:0];
      REG_BIG_LIM:     regs.big_lim = val;
      REG_BIG_HOLD:    regs.big_hold = val[TIME_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic cfg_t moderate_cfg(bit use_ki);
    cfg_t c;
    c.kp = GAIN_W'($urandom);
    c.ki = use_ki ? GAIN_W'($urandom_range(1, 65535)) : '0;
    c.kd = GAIN_W'($urandom);
    c.integral_band = LIM_W'($urandom_range(1, 1 << 20));
    c.small_lim = LIM_W'($urandom_range(1, 4096));
    c.small_hold = TIME_W'($urandom_range(1, 400));
    c.big_lim = c.small_lim + LIM_W'($urandom_range(1, 1 << 18));
    c.big_hold = TIME_W'($urandom_range(1, 800));
    return c;
  endfunction

  task automatic check_result(logic [39:0] beat);
    tick_out_t want;
    logic signed [DRIVE_W-1:0] got_drive;
    logic [2:0] got_status;
    got_drive = beat[31:0];
    got_status = beat[34:32];
    results_seen++;
    status_seen[got_status]++;
    if (pending_ticks.size() == 0) begin
      bad_results++;
      if (bad_results <= 10)
        $display("unexpected transaction: drive %0d status %0d", got_drive, got_status);
      return;
    end
    want = pending_ticks.pop_front();
    if (got_drive !== want.drive || got_status !== want.status) begin
      bad_results++;
      if (bad_results <= 10)
        $display("result %0d: expected drive %0d status %0d, got drive %0d status %0d",
                 results_seen - 1, want.drive, want.status, got_drive, got_status);
    end
  endtask

  // output side: checking, random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic signed [MEAS_W-1:0] meas,
                           input logic signed [MEAS_W-1:0] setp, input logic oc);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {setp, meas};
    s_tuser <= oc;
    do @(posedge clk); while (!s_tready);
    pending_ticks.push_back(control_tick(meas, setp, oc));
    ticks_sent++;
  endtask

  task automatic send_err(input longint e, input logic oc);
    longint m, sp;
    if (e > ERR_CLAMP) e = ERR_CLAMP;
    if (e < -ERR_CLAMP) e = -ERR_CLAMP;
    if (e >= 0) m = longint'($urandom_range(0, MEAS_SPAN - e)) - MEAS_OFS;
    else m = longint'($urandom_range(-e, MEAS_SPAN)) - MEAS_OFS;
    sp = m + e;
    send_tick(m[MEAS_W-1:0], sp[MEAS_W-1:0], oc);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c, input bit spare);
    logic [IDX_W-1:0] idx;
    logic [23:0] val;
    for (int i = 0; i <= int'(REG_BIG_HOLD) + int'(spare); i++) begin
      idx = IDX_W'(i);
      case (idx)
        REG_KP:          val = {8'($urandom), c.kp};
        REG_KI:          val = {8'($urandom), c.ki};
        REG_KD:          val = {8'($urandom), c.kd};
        REG_INTEG_BAND:  val = c.integral_band;
        REG_SMALL_LIM:   val = c.small_lim;
        REG_SMALL_HOLD:  val = {8'($urandom), c.small_hold};
        REG_BIG_LIM:     val = c.big_lim;
        REG_BIG_HOLD:    val = {8'($urandom), c.big_hold};
        default: begin
          idx = IDX_W'($urandom_range(int'(REG_UNUSED), 255));
          val = 24'($urandom);
        end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx, val);
    end
    cfg_valid <= 1'b0;
  endtask

  // episodes shaped to walk the settle timers into each exit
  task automatic random_traffic(input int n);
    int start, len, roll;
    longint e, se, be;
    episode_t ep;
    start = ticks_sent;
    se = longint'(regs.small_lim);
    be = longint'(regs.big_lim);
    if (se == 0) se = 64;
    if (be <= se) be = se + 1024;
    while (ticks_sent - start < n) begin
      roll = $urandom_range(99);
      if (roll < 30) ep = EP_CONVERGE;
      else if (roll < 58) ep = EP_HOVER;
      else if (roll < 76) ep = EP_HOLD;
      else if (roll < 88) ep = EP_OVERLOAD;
      else ep = EP_NOISE;
      case (ep)
        EP_CONVERGE: begin
          e = rand_sign(be + $urandom_range(0, 65535));
          len = $urandom_range(3, 15);
          for (int k = 0; k < len; k++) send_err(e - e * k / len, 1'b0);
          repeat ($urandom_range(5, 50)) send_err(rand_sign($urandom_range(0, se - 1)), 1'b0);
        end
        EP_HOVER: begin
          repeat ($urandom_range(5, 90)) send_err(rand_sign($urandom_range(se, be - 1)), 1'b0);
        end
        EP_HOLD: begin
          e = rand_sign(be + $urandom_range(0, 65535));
          repeat ($urandom_range(20, 70)) send_err(e, 1'b0);
        end
        EP_OVERLOAD: begin
          repeat ($urandom_range(80, 130))
            send_err(rand_sign(be + $urandom_range(0, 65535)), 1'b1);
        end
        default: begin
          repeat ($urandom_range(1, 6)) send_tick(24'($urandom), 24'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_reset_state();
    repeat (2) send_tick(24'($urandom), 24'($urandom), 1'b1);
    send_tick(24'h7FFFFF, 24'h800000, 1'b0);
    wait_idle();
  endtask

  task automatic test_extremes();
    cfg_t c;
    c.kp = 16'sh7FFF;
    c.ki = 16'sh8000;
    c.kd = 16'sh8000;
    c.integral_band = '1;
    c.small_lim = 24'd1;
    c.small_hold = '1;
    c.big_lim = 24'd1;
    c.big_hold = '1;
    program_regs(c, 1'b1);
    send_tick(24'h800000, 24'h7FFFFF, 1'b0);
    send_tick(24'h7FFFFF, 24'h800000, 1'b1);
    send_tick(24'h000000, 24'h000000, 1'b0);
    send_tick(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_tick(24'h800000, 24'h800000, 1'b0);
    send_tick(24'h800000, 24'h7FFFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_integral_band();
    cfg_t c;
    longint errs[12];
    c.kp = 16'sd64;
    c.ki = 16'sd256;
    c.kd = 16'sd32;
    c.integral_band = 24'd100;
    c.small_lim = 24'd3;
    c.small_hold = 16'd20;
    c.big_lim = 24'd40;
    c.big_hold = 16'd30;
    errs = '{50, 99, 100, 101, 99, -1, -99, 0, 0, 2, 2, -2};
    program_regs(c, 1'b0);
    foreach (errs[i]) send_err(errs[i], 1'b0);
    wait_idle();
  endtask

  task automatic test_steady_stream();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    program_regs(moderate_cfg(1'b1), 1'b0);
    random_traffic(500);
    wait_idle();
  endtask

  task automatic test_sender_gaps();
    cfg_t c;
    c.kp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    c.ki = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    c.kd = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    c.integral_band = '1;
    c.small_lim = '1;
    c.small_hold = '1;
    c.big_lim = '1;
    c.big_hold = '1;
    src_idle_pct = 74;
    sink_stall_pct = 0;
    program_regs(c, 1'b0);
    random_traffic(350);
    wait_idle();
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct = 0;
    sink_stall_pct = 74;
    program_regs(moderate_cfg(1'b0), 1'b0);
    random_traffic(500);
    wait_idle();
  endtask

  task automatic test_mixed_idle();
    src_idle_pct = 28;
    sink_stall_pct = 28;
    program_regs(moderate_cfg(1'b1), 1'b0);
    random_traffic(450);
    wait_idle();
  endtask

  task automatic test_missing_limit();
    cfg_t c;
    c = moderate_cfg(1'b1);
    case ($urandom_range(3))
      0: c.small_lim = '0;
      1: c.small_hold = '0;
      2: c.big_lim = '0;
      default: c.big_hold = '0;
    endcase
    src_idle_pct = 28;
    sink_stall_pct = 28;
    program_regs(c, 1'b0);
    random_traffic(100);
    wait_idle();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    program_regs(moderate_cfg(1'b1), 1'b0);
    hold_tgl <= ~hold_tgl;
    random_traffic(60);
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extremes();
    test_integral_band();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_missing_limit();
    test_backpressure();
    $display("%0d ticks over 8 register settings, %0d results checked", ticks_sent,
             results_seen);
    $display("exits seen: small %0d, big %0d, velocity %0d, overcurrent %0d, no limits %0d",
             status_seen[ST_SMALL], status_seen[ST_BIG], status_seen[ST_VELOCITY],
             status_seen[ST_CURRENT], status_seen[ST_MISSING]);
    if (bad_results == 0 && pending_ticks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
